// File: src/blu_pkg.sv
// Shared types and constants of the bounded ordered list unit.
package blu_pkg;

	// Fixed field widths of the request and response items
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 6;
	localparam int LENGTH_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_END   = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DELETE    = 3'd3,
		OP_DUMP      = 3'd4
	} blu_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_BOUNDS  = 3'd2,
		ST_FULL    = 3'd3,
		ST_NOKEY   = 3'd4
	} blu_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK
	} blu_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;  // latch the request item
		logic execute;  // run a one-shot operation
		logic step;     // advance the rotation walk by one entry
		logic emit;     // load the response register
	} blu_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic walk_op;     // delete or dump
		logic walk_empty;  // list holds no entry
		logic final_step;  // walk is at its last entry
		logic is_dump;
	} blu_sts_t;

endpackage

// File: src/blu_if.sv
// Request and response channel interfaces of the bounded ordered list unit.
interface blu_req_if;
	logic                               valid;
	logic                               ready;
	logic        [blu_pkg::OP_W-1:0]    op;
	logic signed [blu_pkg::VALUE_W-1:0] value;
	logic        [blu_pkg::POS_W-1:0]   position;

	modport source (output valid, output op, output value, output position, input ready);
	modport sink (input valid, input op, input value, input position, output ready);
endinterface

interface blu_rsp_if;
	logic                                valid;
	logic                                ready;
	logic        [blu_pkg::STATUS_W-1:0] status;
	logic                                has_value;
	logic signed [blu_pkg::VALUE_W-1:0]  entry_value;
	logic        [blu_pkg::INDEX_W-1:0]  entry_index;
	logic        [blu_pkg::LENGTH_W-1:0] length;
	logic                                last;

	modport source (output valid, output status, output has_value, output entry_value,
		output entry_index, output length, output last, input ready);
	modport sink (input valid, input status, input has_value, input entry_value,
		input entry_index, input length, input last, output ready);
endinterface

// File: src/blu_ctrl.sv
// Controller state machine of the bounded ordered list unit.
module blu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output blu_pkg::blu_cmd_t cmd,
	input  blu_pkg::blu_sts_t sts
);
	import blu_pkg::*;

	blu_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       emit_need;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	// a dump answers on every step, a delete only at the end of its walk
	assign emit_need = sts.is_dump || sts.final_step;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decide next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.walk_op && !sts.walk_empty) begin
					state_d = S_WALK;
				end else if (out_free) begin
					cmd.execute = 1'b1;
					cmd.emit    = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_WALK: begin
				if (!emit_need || out_free) begin
					cmd.step = 1'b1;
					cmd.emit = emit_need;
					if (sts.final_step) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Set valid on a new item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: src/blu_datapath.sv
// Datapath of the bounded ordered list unit: entry cells, walk counters, response register.
module blu_datapath #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  blu_pkg::blu_cmd_t                   cmd,
	output blu_pkg::blu_sts_t                   sts,
	input  logic        [blu_pkg::OP_W-1:0]     in_op,
	input  logic signed [blu_pkg::VALUE_W-1:0]  in_value,
	input  logic        [blu_pkg::POS_W-1:0]    in_position,
	output logic        [blu_pkg::STATUS_W-1:0] status,
	output logic                                has_value,
	output logic signed [blu_pkg::VALUE_W-1:0]  entry_value,
	output logic        [blu_pkg::INDEX_W-1:0]  entry_index,
	output logic        [blu_pkg::LENGTH_W-1:0] length,
	output logic                                last
);
	import blu_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	typedef logic [DATA_WIDTH-1:0] word_t;

	logic [OP_W-1:0]  op_q;
	word_t            word_q;
	logic [POS_W-1:0] pos_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    k_q;
	logic             found_q;
	word_t            cells_q [CAPACITY];

	logic signed [63:0] value_ext;
	logic        [63:0] head_ext;
	word_t              head;
	logic               full;
	logic               ins_ok;
	logic [CW-1:0]      ins_idx;
	blu_status_t        single_st;
	logic               is_dump;
	logic               is_del;
	logic               drop;
	logic [CW-1:0]      last_pos;
	logic               final_step;

	// Sign-extend the request word and keep the stored width
	assign value_ext = 64'(in_value);
	assign head      = cells_q[0];
	assign head_ext  = 64'(head);

	assign is_dump    = (op_q == OP_DUMP);
	assign is_del     = (op_q == OP_DELETE);
	assign full       = (count_q == CW'(CAPACITY));
	assign last_pos   = count_q - CW'(1);
	assign final_step = (k_q == n_q - CW'(1));
	// drop the head entry on the first key match of a delete walk
	assign drop       = cmd.step && is_del && !found_q && (head == word_q);

	assign sts.walk_op    = is_dump || is_del;
	assign sts.walk_empty = (count_q == '0);
	assign sts.final_step = final_step;
	assign sts.is_dump    = is_dump;

	// Decode the one-shot operations
	always_comb begin
		ins_ok    = 1'b0;
		ins_idx   = '0;
		single_st = ST_OK;
		unique case (blu_op_t'(op_q))
			OP_INS_FRONT: begin
				if (full) begin
					single_st = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			OP_INS_END: begin
				ins_idx = count_q;
				if (full) begin
					single_st = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			OP_INS_POS: begin
				ins_idx = CW'(pos_q - POS_W'(1));
				if (pos_q == '0) begin
					single_st = ST_INVALID;
				end else if (full) begin
					single_st = ST_FULL;
				end else if ({1'b0, pos_q} > 9'(count_q) + 9'd1) begin
					single_st = ST_BOUNDS;
				end else begin
					ins_ok = 1'b1;
				end
			end
			OP_DELETE: begin
				// only reached on an empty list
				single_st = ST_NOKEY;
			end
			OP_DUMP: begin
				single_st = ST_OK;
			end
			default: begin
				single_st = ST_OK;
			end
		endcase
	end

	// Latch the request item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			word_q <= value_ext[DATA_WIDTH-1:0];
			pos_q  <= in_position;
		end
	end

	// Track length, walk position and match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			n_q     <= '0;
			k_q     <= '0;
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			n_q     <= count_q;
			k_q     <= '0;
			found_q <= 1'b0;
		end else if (cmd.execute && ins_ok) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.step) begin
			k_q <= k_q + CW'(1);
			if (drop) begin
				found_q <= 1'b1;
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Entry cells: shift down on insert, rotate left through the head on a walk
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t up_w;
		word_t down_w;
		if (i == CAPACITY - 1) begin : g_top
			assign up_w = cells_q[0];
		end else begin : g_mid
			assign up_w = cells_q[i+1];
		end
		if (i == 0) begin : g_first
			assign down_w = cells_q[0];
		end else begin : g_rest
			assign down_w = cells_q[i-1];
		end
		always_ff @(posedge clk) begin
			if (cmd.execute && ins_ok) begin
				if (CW'(i) == ins_idx) begin
					cells_q[i] <= word_q;
				end else if (CW'(i) > ins_idx) begin
					cells_q[i] <= down_w;
				end
			end else if (cmd.step) begin
				if (drop || CW'(i) != last_pos) begin
					cells_q[i] <= up_w;
				end else begin
					cells_q[i] <= cells_q[0];
				end
			end
		end
	end

	// Load the response register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (cmd.step && is_dump) begin
				status      <= ST_OK;
				has_value   <= 1'b1;
				entry_value <= head_ext[VALUE_W-1:0];
				entry_index <= INDEX_W'(k_q);
				length      <= LENGTH_W'(count_q);
				last        <= final_step;
			end else if (cmd.step) begin
				status      <= (found_q || drop) ? ST_OK : ST_NOKEY;
				has_value   <= 1'b0;
				entry_value <= '0;
				entry_index <= '0;
				length      <= drop ? LENGTH_W'(count_q - CW'(1)) : LENGTH_W'(count_q);
				last        <= 1'b1;
			end else begin
				status      <= single_st;
				has_value   <= 1'b0;
				entry_value <= '0;
				entry_index <= '0;
				length      <= ins_ok ? LENGTH_W'(count_q) + LENGTH_W'(1) : LENGTH_W'(count_q);
				last        <= 1'b1;
			end
		end
	end

endmodule

// File: src/bounded_ordered_list_unit.sv
// Top level of the bounded ordered list unit.
//
// Keeps an ordered list of up to CAPACITY words in a row of register cells and runs one
// operation per request item: insert at front, at end or at a 1-based position, delete
// the first entry equal to a key, or dump the list. An insert, an unknown op and a delete
// or dump of an empty list are latched, then executed, and give one response item.
// A delete or dump of n entries is latched, then walked: the cell row rotates one
// entry a cycle through the head cell, where the key is compared or the entry sent out,
// and comes back to its order after n steps. A dump gives n response items, the final
// one with last set; a stalled response channel holds the walk. The next request item
// is taken once the block is back in idle, even while the final response still waits.
module bounded_ordered_list_unit #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	blu_req_if.sink   req,
	blu_rsp_if.source rsp
);
	import blu_pkg::*;

	blu_cmd_t cmd;
	blu_sts_t sts;

	blu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	blu_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_op       (req.op),
		.in_value    (req.value),
		.in_position (req.position),
		.status      (rsp.status),
		.has_value   (rsp.has_value),
		.entry_value (rsp.entry_value),
		.entry_index (rsp.entry_index),
		.length      (rsp.length),
		.last        (rsp.last)
	);

endmodule

// File: src/blu_checker.sv
// Port-level assertions of the bounded ordered list unit and their bind.
module blu_checker #(
	parameter int CAPACITY = 16
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic        [blu_pkg::STATUS_W-1:0] status,
	input logic                                has_value,
	input logic signed [blu_pkg::VALUE_W-1:0]  entry_value,
	input logic        [blu_pkg::INDEX_W-1:0]  entry_index,
	input logic        [blu_pkg::LENGTH_W-1:0] length,
	input logic                                last
);
	import blu_pkg::*;

	// Hold a stalled response item
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_value) && $stable(status)
			&& $stable(entry_index) && $stable(last))
		else $error("stalled response item changed");

	// One operation at a time: no request taken in the cycle after one was taken
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	// Only a dump entry carries a value, and it always reports ok
	a_dump_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && has_value |-> status == ST_OK)
		else $error("dumped entry with error status");

	// Every response but the final one of an item is a dumped entry
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> has_value)
		else $error("non-final response without entry");

	// Dumped index lies inside the list, and the list within capacity
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> length <= LENGTH_W'(CAPACITY)
			&& (!has_value || LENGTH_W'(entry_index) < length))
		else $error("index or length out of range");

endmodule

bind bounded_ordered_list_unit blu_checker #(
	.CAPACITY (CAPACITY)
) u_blu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.has_value   (rsp.has_value),
	.entry_value (rsp.entry_value),
	.entry_index (rsp.entry_index),
	.length      (rsp.length),
	.last        (rsp.last)
);

// File: sim/bounded_ordered_list_unit_tb.sv
// Testbench for the bounded ordered list unit: directed, full-list, backpressure and random runs.
`timescale 1ns / 100ps

module bounded_ordered_list_unit_tb;
	import blu_pkg::*;

	localparam int LIST_CAP    = 16;
	localparam int TAIL_CYCLES = LIST_CAP + 8;

	// One response item as the list should produce it
	typedef struct packed {
		blu_status_t                status;
		logic                       has_value;
		logic signed [VALUE_W-1:0]  entry_value;
		logic        [INDEX_W-1:0]  entry_index;
		logic        [LENGTH_W-1:0] length;
		logic                       last;
	} list_rsp_t;

	logic clk;
	logic arst_n;

	blu_req_if req_ch();
	blu_rsp_if rsp_ch();

	// Shadow copy of the list and the responses still owed by the block
	logic signed [VALUE_W-1:0] list_q[$];
	list_rsp_t                 rsp_expected[$];

	int unsigned err_cnt;
	int unsigned hold_len;
	int unsigned hold_trigger;
	logic        stall_on;

	bounded_ordered_list_unit #(
		.CAPACITY(LIST_CAP),
		.DATA_WIDTH(VALUE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Queue one owed response, with the length as the list stands now
	function automatic void owe_rsp(blu_status_t st, logic has, logic signed [VALUE_W-1:0] val,
		logic [INDEX_W-1:0] idx, logic is_last);
		list_rsp_t r;
		r.status      = st;
		r.has_value   = has;
		r.entry_value = val;
		r.entry_index = idx;
		r.length      = LENGTH_W'(list_q.size());
		r.last        = is_last;
		rsp_expected.push_back(r);
	endfunction

	// Apply one operation to the shadow list and queue the responses it causes
	function automatic void list_apply(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
		logic [POS_W-1:0] pos);
		blu_status_t st;
		st = ST_OK;
		case (op)
			OP_INS_FRONT: begin
				if (list_q.size() >= LIST_CAP)
					st = ST_FULL;
				else
					list_q.push_front(value);
			end
			OP_INS_END: begin
				if (list_q.size() >= LIST_CAP)
					st = ST_FULL;
				else
					list_q.push_back(value);
			end
			OP_INS_POS: begin
				// invalid position wins over full, full wins over bounds
				if (pos == '0)
					st = ST_INVALID;
				else if (list_q.size() >= LIST_CAP)
					st = ST_FULL;
				else if (int'(pos) > list_q.size() + 1)
					st = ST_BOUNDS;
				else
					list_q.insert(int'(pos) - 1, value);
			end
			OP_DELETE: begin
				st = ST_NOKEY;
				for (int i = 0; i < list_q.size(); i++) begin
					if (list_q[i] == value) begin
						list_q.delete(i);
						st = ST_OK;
						break;
					end
				end
			end
			OP_DUMP: begin
				if (list_q.size() == 0)
					owe_rsp(ST_OK, 1'b0, '0, '0, 1'b1);
				for (int i = 0; i < list_q.size(); i++)
					owe_rsp(ST_OK, 1'b1, list_q[i], INDEX_W'(i), i == list_q.size() - 1);
				return;
			end
			default: begin
			end
		endcase
		owe_rsp(st, 1'b0, '0, '0, 1'b1);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			err_cnt++;
		end
	endfunction

	// Data word with a bias toward duplicates and extremes
	function automatic logic signed [VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2, 3, 4: return VALUE_W'($urandom_range(0, 7)) - 32'sd4;
			default: return $urandom;
		endcase
	endfunction

	// Check each accepted response against the oldest owed one
	always @(posedge clk) begin : rsp_check
		list_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_expected.size() == 0) begin
				$display("%0t ns: unexpected response item: expected none, actual status %0d",
					$time, rsp_ch.status);
				err_cnt++;
			end else begin
				want = rsp_expected.pop_front();
				check_field("status", 32'(want.status), 32'(rsp_ch.status));
				check_field("has_value", 32'(want.has_value), 32'(rsp_ch.has_value));
				check_field("entry_value", want.entry_value, rsp_ch.entry_value);
				check_field("entry_index", 32'(want.entry_index), 32'(rsp_ch.entry_index));
				check_field("length", 32'(want.length), 32'(rsp_ch.length));
				check_field("last", 32'(want.last), 32'(rsp_ch.last));
			end
		end
	end

	// Drive response ready: rotating stall pattern, plus a long hold-off on request
	initial begin : rsp_ready_drive
		int unsigned hold_seen;
		int unsigned hold_left;
		int unsigned rot_cnt;
		logic [15:0] pattern;
		hold_seen = 0;
		hold_left = 0;
		rot_cnt   = 0;
		pattern   = '1;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = hold_len;
			end
			// reload the pattern every full rotation, sometimes with no stalls at all
			if (rot_cnt == 0) begin
				pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
				if (pattern == '0)
					pattern = 16'h0001;
			end
			rot_cnt = (rot_cnt + 1) % 16;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !stall_on || pattern[0];
			end
			pattern = {pattern[0], pattern[15:1]};
		end
	end

	// Offer one item and wait until the block takes it
	task automatic send_item(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
		logic [POS_W-1:0] pos);
		@(negedge clk);
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.value    <= value;
		req_ch.position <= pos;
		do @(posedge clk); while (!req_ch.ready);
		list_apply(op, value, pos);
	endtask

	// Drop valid and leave the request channel idle
	task automatic idle_cycles(int unsigned n);
		repeat (n) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		idle_cycles(1);
		while (rsp_expected.size() != 0)
			@(posedge clk);
	endtask

	// Empty list cases, every op, field extremes, precedence of position checks
	task automatic test_directed();
		stall_on = 1'b0;
		send_item(OP_DUMP, '0, '0);
		send_item(OP_DELETE, 32'sd5, 8'hFF);
		for (int k = int'(OP_DUMP) + 1; k < (1 << OP_W); k++)
			send_item(OP_W'(k), 32'sh7FFF_FFFF, 8'hFF);
		send_item(OP_INS_POS, 32'sd1, 8'd0);
		send_item(OP_INS_POS, 32'sd1, 8'd2);
		send_item(OP_INS_POS, 32'sd1, 8'd255);
		send_item(OP_INS_POS, 32'sh8000_0000, 8'd1);
		send_item(OP_INS_FRONT, 32'sh7FFF_FFFF, '0);
		send_item(OP_INS_END, -32'sd1, '0);
		send_item(OP_INS_POS, 32'sd0, 8'd4);
		send_item(OP_INS_POS, 32'sh5555_5555, 8'd2);
		send_item(OP_INS_END, 32'sh5555_5555, '0);
		send_item(OP_DUMP, '0, '0);
		// delete the first of two equal entries, then a missing key
		send_item(OP_DELETE, 32'sh5555_5555, '0);
		send_item(OP_DELETE, 32'sd12345, '0);
		send_item(OP_DELETE, 32'sh8000_0000, '0);
		send_item(OP_DUMP, '0, '0);
		wait_drained();
	endtask

	// Fill the list, then hit every insert path on a full list
	task automatic test_full_list();
		stall_on = 1'b1;
		while (list_q.size() < LIST_CAP)
			send_item(OP_INS_END, pick_word(), POS_W'($urandom));
		send_item(OP_INS_FRONT, 32'sd1, '0);
		send_item(OP_INS_END, 32'sd2, '0);
		send_item(OP_INS_POS, 32'sd3, 8'd0);
		send_item(OP_INS_POS, 32'sd3, 8'd255);
		send_item(OP_INS_POS, 32'sd3, 8'd1);
		send_item(OP_DUMP, '0, '0);
		send_item(OP_DELETE, list_q[LIST_CAP-1], '0);
		send_item(OP_DELETE, list_q[0], '0);
		send_item(OP_INS_POS, 32'sh0F0F_0F0F, POS_W'(list_q.size() + 1));
		send_item(OP_DUMP, '0, '0);
		wait_drained();
	endtask

	// Hold the response side off while items keep coming, then pause until drained
	task automatic test_backpressure();
		stall_on = 1'b0;
		hold_len = 300;
		hold_trigger++;
		repeat (24) begin
			if ($urandom_range(0, 3) == 0)
				send_item(OP_DUMP, '0, '0);
			else
				send_item(OP_INS_FRONT, pick_word(), POS_W'($urandom));
		end
		wait_drained();
	endtask

	// Random operations in bursts, steered to keep the list between empty and full
	task automatic test_random_ops(int unsigned n_items);
		int unsigned      done;
		int unsigned      burst_left;
		int unsigned      pick;
		int unsigned      ins_bias;
		logic [OP_W-1:0]  op;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0] pos;
		stall_on   = 1'b1;
		done       = 0;
		burst_left = 0;
		while (done < n_items) begin
			if (burst_left == 0) begin
				idle_cycles($urandom_range(1, 8));
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
			value    = pick_word();
			pos      = POS_W'($urandom);
			ins_bias = (list_q.size() < 4) ? 75 : (list_q.size() > 13) ? 30 : 55;
			pick     = $urandom_range(0, 99);
			if (pick < 3) begin
				op = OP_W'($urandom_range(int'(OP_DUMP) + 1, (1 << OP_W) - 1));
			end else if (pick < 11) begin
				op = OP_DUMP;
			end else if ($urandom_range(0, 99) < ins_bias) begin
				case ($urandom_range(0, 2))
					0: op = OP_INS_FRONT;
					1: op = OP_INS_END;
					default: begin
						op = OP_INS_POS;
						if ($urandom_range(0, 9) == 0)
							pos = '0;
						else if ($urandom_range(0, 9) != 0)
							pos = POS_W'($urandom_range(1, list_q.size() + 1));
					end
				endcase
			end else begin
				op = OP_DELETE;
				if (list_q.size() != 0 && $urandom_range(0, 9) < 8)
					value = list_q[$urandom_range(0, list_q.size() - 1)];
			end
			send_item(op, value, pos);
			if (op <= OP_DUMP)
				done++;
		end
		wait_drained();
	endtask

	initial begin
		err_cnt         = 0;
		hold_len        = 0;
		hold_trigger    = 0;
		stall_on        = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.op       = '0;
		req_ch.value    = '0;
		req_ch.position = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_list();
		test_backpressure();
		test_random_ops(240);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("[bounded_ordered_list_unit] OK");
		else
			$display("[bounded_ordered_list_unit] ERROR");
		$finish;
	end

	// Stop a hung run
	initial begin
		#3_000_000;
		$display("[bounded_ordered_list_unit] ERROR");
		$finish;
	end

endmodule
